// ----- hdl/bpr_pkg.sv -----
package bpr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int X_WIDTH   = 20;
    localparam int MAX_STEPS = 40;
    localparam int TOL_WIDTH = 20;
    localparam int STEP_W    = 6;

    localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(16);

    typedef enum logic [1:0] {
        ST_NARROW  = 2'd0,
        ST_ZERO    = 2'd1,
        ST_NO_ROOT = 2'd2,
        ST_CAP     = 2'd3
    } status_t;

    typedef struct packed {
        logic                      op;
        logic signed [X_WIDTH-1:0] left_end;
        logic signed [X_WIDTH-1:0] right_end;
    } item_t;

    typedef struct packed {
        logic signed [X_WIDTH-1:0] root;
        logic [1:0]                status;
        logic [STEP_W-1:0]         steps_taken;
    } result_t;

endpackage

// ----- hdl/bisection_polynomial_root_core.sv -----
// Bisection root finder for g = 5x^3-2x^2+3 (op 0) or h = x^4-3x^2-8 (op 1) on
// signed Q4.16 endpoints. Pulse start while busy is low to hand in an item; busy
// stays high until the cycle in which the result appears, so the next item can
// be taken in that same cycle. The result appears for exactly one cycle with
// result_valid and cannot be stalled, so the receiver must take it then. An item
// with no sign change at the ends finishes as soon as both ends are evaluated.
// Otherwise each of the N halvings (N at most 40) runs through a seven-step
// microcode loop that evaluates the polynomial on one shared multiplier, and the
// item finishes when the width drops below the tolerance, at the step cap, or
// when the midpoint is an exact zero. The tolerance register may be written at
// any time but should only be changed while busy is low.
module bisection_polynomial_root_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  bpr_pkg::item_t                        item,
    output logic                                  result_valid,
    output bpr_pkg::result_t                      result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bpr_pkg::TOL_WIDTH-1:0]         cfg_data
);
    import bpr_pkg::*;

    localparam int X2_W   = 2 * X_WIDTH - FRAC_BITS;
    localparam int MUL_W  = (X2_W > X_WIDTH) ? X2_W : X_WIDTH;
    localparam int PROD_W = 2 * MUL_W;
    localparam int HI_W   = PROD_W - FRAC_BITS;
    localparam int ACC_W  = HI_W + 4;
    localparam int PC_W   = 5;

    typedef enum logic [2:0] {
        C_NEXT, C_ALWAYS, C_WAIT, C_SAME_SIGN, C_NARROW, C_CAP, C_ZERO
    } cond_t;
    typedef enum logic [1:0] { M_NONE, M_SQUARE, M_HIGH } mul_t;
    typedef enum logic [1:0] { D_NONE, D_LEFT, D_RIGHT, D_MID } dst_t;
    typedef enum logic [1:0] { X_NONE, X_RIGHT, X_MID } xsel_t;

    typedef struct packed {
        cond_t            cond;
        logic [PC_W-1:0]  target;
        mul_t             mul;
        dst_t             dst;
        xsel_t            xld;
        logic             halve;
        logic             emit;
        status_t          st;
    } uword_t;

    localparam logic [PC_W-1:0] A_IDLE    = 5'd0;
    localparam logic [PC_W-1:0] A_LOOP    = 5'd8;
    localparam logic [PC_W-1:0] A_NO_ROOT = 5'd15;
    localparam logic [PC_W-1:0] A_NARROW  = 5'd16;
    localparam logic [PC_W-1:0] A_CAP     = 5'd17;
    localparam logic [PC_W-1:0] A_ZERO    = 5'd18;

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{C_NEXT, A_IDLE, M_NONE, D_NONE, X_NONE, 1'b0, 1'b0, ST_NARROW};
        case (pc)
            5'd0:  w.cond = C_WAIT;
            5'd1:  w.mul  = M_SQUARE;
            5'd2:  w.mul  = M_HIGH;
            5'd3:
            begin
                w.dst = D_LEFT;
                w.xld = X_RIGHT;
            end
            5'd4:  w.mul  = M_SQUARE;
            5'd5:  w.mul  = M_HIGH;
            5'd6:  w.dst  = D_RIGHT;
            5'd7:
            begin
                w.cond   = C_SAME_SIGN;
                w.target = A_NO_ROOT;
            end
            5'd8:
            begin
                w.cond   = C_NARROW;
                w.target = A_NARROW;
                w.xld    = X_MID;
            end
            5'd9:
            begin
                w.cond   = C_CAP;
                w.target = A_CAP;
            end
            5'd10: w.mul  = M_SQUARE;
            5'd11: w.mul  = M_HIGH;
            5'd12: w.dst  = D_MID;
            5'd13:
            begin
                w.cond   = C_ZERO;
                w.target = A_ZERO;
            end
            5'd14:
            begin
                w.cond   = C_ALWAYS;
                w.target = A_LOOP;
                w.halve  = 1'b1;
            end
            5'd15:
            begin
                w.cond = C_ALWAYS;
                w.emit = 1'b1;
                w.st   = ST_NO_ROOT;
            end
            5'd16:
            begin
                w.cond = C_ALWAYS;
                w.emit = 1'b1;
                w.st   = ST_NARROW;
            end
            5'd17:
            begin
                w.cond = C_ALWAYS;
                w.emit = 1'b1;
                w.st   = ST_CAP;
            end
            5'd18:
            begin
                w.cond = C_ALWAYS;
                w.emit = 1'b1;
                w.st   = ST_ZERO;
            end
            default: w.cond = C_ALWAYS;
        endcase
        return w;
    endfunction

    logic [PC_W-1:0]            pc_reg, pc_next;
    logic [TOL_WIDTH-1:0]       tol_reg;
    logic                       op_reg;
    logic signed [X_WIDTH-1:0]  l_reg, r_reg, x_reg;
    logic signed [X2_W-1:0]     x2_reg;
    logic signed [PROD_W-1:0]   p_reg;
    logic [1:0]                 sl_reg, sr_reg, sm_reg;   // {positive, negative}
    logic [STEP_W-1:0]          steps_reg;
    logic                       valid_reg;
    result_t                    res_reg;

    uword_t                     uw;
    logic                       accept;
    logic signed [X_WIDTH:0]    sum, diff;
    logic [X_WIDTH:0]           width;
    logic signed [X_WIDTH-1:0]  mid;
    logic signed [HI_W-1:0]     hi;
    logic signed [X2_W-1:0]     x2_now;
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [ACC_W-1:0]    acc_hi, acc_x2, poly;
    logic [1:0]                 sgn;
    logic                       cond_true;

    assign uw        = ucode(pc_reg);
    assign busy      = (pc_reg != A_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign sum   = {l_reg[X_WIDTH-1], l_reg} + {r_reg[X_WIDTH-1], r_reg};
    assign diff  = {r_reg[X_WIDTH-1], r_reg} - {l_reg[X_WIDTH-1], l_reg};
    assign width = diff[X_WIDTH] ? (X_WIDTH+1)'(-diff) : diff;
    assign mid   = sum[X_WIDTH:1];

    // Upper part of the last product is the floored Q-format value.
    assign hi     = p_reg[PROD_W-1:FRAC_BITS];
    assign x2_now = hi[X2_W-1:0];

    always_comb
    begin
        mul_a = MUL_W'(x_reg);
        mul_b = MUL_W'(x_reg);
        if (uw.mul == M_HIGH)
        begin
            mul_a = MUL_W'(x2_now);
            mul_b = op_reg ? MUL_W'(x2_now) : MUL_W'(x_reg);
        end
    end

    assign acc_hi = ACC_W'(hi);
    assign acc_x2 = ACC_W'(x2_reg);

    always_comb
    begin
        if (!op_reg)
            poly = (acc_hi <<< 2) + acc_hi - (acc_x2 <<< 1)
                   + (ACC_W'(3) <<< FRAC_BITS);
        else
            poly = acc_hi - (acc_x2 <<< 1) - acc_x2 - (ACC_W'(8) <<< FRAC_BITS);
        sgn = {!poly[ACC_W-1] && (poly != '0), poly[ACC_W-1]};
    end

    always_comb
    begin
        case (uw.cond)
            C_NEXT:      cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_WAIT:      cond_true = !start;
            C_SAME_SIGN: cond_true = (sl_reg[1] && sr_reg[1]) || (sl_reg[0] && sr_reg[0]);
            C_NARROW:    cond_true = width < {1'b0, tol_reg};
            C_CAP:       cond_true = steps_reg >= STEP_W'(MAX_STEPS);
            C_ZERO:      cond_true = (sm_reg == 2'b00);
            default:     cond_true = 1'b0;
        endcase
        pc_next = cond_true ? uw.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= A_IDLE;
            tol_reg   <= TOL_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg    <= pc_next;
            valid_reg <= uw.emit;
            if (cfg_valid && cfg_ready)
                tol_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= item.op;
            l_reg     <= item.left_end;
            r_reg     <= item.right_end;
            x_reg     <= item.left_end;
            steps_reg <= '0;
        end
        else
        begin
            case (uw.xld)
                X_RIGHT: x_reg <= r_reg;
                X_MID:   x_reg <= mid;
                default: x_reg <= x_reg;
            endcase
            if (uw.halve)
            begin
                // Keep the left half only on a strict sign change.
                if ((sl_reg[1] && sm_reg[0]) || (sl_reg[0] && sm_reg[1]))
                    r_reg <= mid;
                else
                begin
                    l_reg  <= mid;
                    sl_reg <= sm_reg;
                end
                steps_reg <= steps_reg + 1'b1;
            end
        end

        if (uw.mul != M_NONE)
            p_reg <= mul_a * mul_b;
        if (uw.mul == M_HIGH)
            x2_reg <= x2_now;

        case (uw.dst)
            D_LEFT:  sl_reg <= sgn;
            D_RIGHT: sr_reg <= sgn;
            D_MID:   sm_reg <= sgn;
            default: ;
        endcase

        if (uw.emit)
        begin
            res_reg.root        <= (uw.st == ST_NO_ROOT) ? '0 : mid;
            res_reg.status      <= uw.st;
            res_reg.steps_taken <= steps_reg;
        end
    end

    assign result_valid = valid_reg;
    assign result       = res_reg;

endmodule
